/* rtl/core/eeprom_image_checksum_builder_assert.svh */
// Assertion helpers, clocked on clk, quiet while arst_n is low.
`ifndef EEPROM_IMAGE_CHECKSUM_BUILDER_ASSERT_SVH
`define EEPROM_IMAGE_CHECKSUM_BUILDER_ASSERT_SVH

// Same-cycle implication.
`define EICB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eicb: same-cycle check failed");

// Next-cycle implication.
`define EICB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eicb: next-cycle check failed");

`endif

/* rtl/core/eicb_pkg.sv */
package eicb_pkg;

	localparam int IMAGE_BYTES_DEF = 128;
	localparam logic [15:0] SUM_START = 16'hAAAA;

	localparam logic [1:0] CMD_RESTART = 2'd0;
	localparam logic [1:0] CMD_APPEND  = 2'd1;
	localparam logic [1:0] CMD_FINISH  = 2'd2;
	localparam logic [1:0] CMD_READ    = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
		logic [6:0] read_address;
	} eicb_cmd_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        status;
		logic [15:0] checksum;
		logic [7:0]  fill_level;
	} eicb_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_WR_LO,
		ST_WR_HI,
		ST_RESULT
	} eicb_state_t;

endpackage

/* rtl/core/eicb_sum_unit.sv */
module eicb_sum_unit (
	input  logic [15:0] sum,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  prev_byte,
	input  logic        odd,
	output logic [15:0] sum_next
);
	import eicb_pkg::*;

	logic [15:0] mixed;

	// fold odd byte into high half, preceding even byte into low half, rotate left
	assign mixed    = sum ^ {data_byte, prev_byte};
	assign sum_next = odd ? {mixed[14:0], mixed[15]} : sum;

endmodule

/* rtl/core/eicb_image_ram.sv */
module eicb_image_ram #(
	parameter int DEPTH = eicb_pkg::IMAGE_BYTES_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	import eicb_pkg::*;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/eeprom_image_checksum_builder.sv */
// Restart, append and read go from idle to the result state; finish first pads zero
// bytes (fill up to N-2), then writes the checksum low and high bytes into the last two
// slots. One item in flight: the next item is taken once the result is registered,
// one padded byte per cycle through the shared checksum unit.
// Reset (arst_n low): fill pointer 0, checksum 0xAAAA, no result pending;
// image RAM contents are not cleared.
`include "eeprom_image_checksum_builder_assert.svh"

module eeprom_image_checksum_builder #(
	parameter int IMAGE_BYTES = eicb_pkg::IMAGE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  eicb_pkg::eicb_cmd_t cmd_item,
	output logic              res_valid,
	input  logic              res_stall,
	output eicb_pkg::eicb_res_t res_item
);
	import eicb_pkg::*;

	localparam int AW = $clog2(IMAGE_BYTES);
	localparam int FW = $clog2(IMAGE_BYTES + 1);

	// sequencer state
	eicb_state_t state_q, state_d;

	// architectural state
	logic [FW-1:0] fill_q, fill_d;   // next write position, can reach IMAGE_BYTES
	logic [15:0]   sum_q, sum_d;     // running checksum
	logic [7:0]    prev_q;           // last byte written at an even position

	// per-item capture
	logic [1:0]    cmd_code_q;
	logic          status_q;
	logic          rd_ok_q;

	// result register
	logic          res_valid_q;
	eicb_res_t     res_q;

	// datapath controls
	logic          accept;
	logic          capture;
	logic          res_load;
	logic          full;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic [7:0]    sum_byte;
	logic [15:0]   sum_next;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign full      = (fill_q == FW'(IMAGE_BYTES));
	assign raddr     = AW'(cmd_item.read_address);

	// Shared checksum unit: used by an append and by every padded byte.
	// Only odd positions change the sum; the even partner comes from prev_q.
	eicb_sum_unit u_sum (
		.sum       (sum_q),
		.data_byte (sum_byte),
		.prev_byte (prev_q),
		.odd       (fill_q[0]),
		.sum_next  (sum_next)
	);

	// Image store: one write port, one registered read port.
	eicb_image_ram #(
		.DEPTH (IMAGE_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath controls
	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		sum_d    = sum_q;
		we       = 1'b0;
		waddr    = fill_q[AW-1:0];
		wdata    = 8'd0;
		sum_byte = 8'd0;
		re       = 1'b0;
		capture  = 1'b0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					capture = 1'b1;
					state_d = ST_RESULT;
					case (cmd_item.command)
						CMD_RESTART: begin
							fill_d = '0;
							sum_d  = SUM_START;
						end
						CMD_APPEND: begin
							if (!full) begin
								we       = 1'b1;
								wdata    = cmd_item.data_byte;
								sum_byte = cmd_item.data_byte;
								sum_d    = sum_next;
								fill_d   = fill_q + FW'(1);
							end
						end
						CMD_FINISH: begin
							state_d = ST_PAD;
						end
						CMD_READ: begin
							re = 1'b1;
						end
						default: begin
							state_d = ST_RESULT;
						end
					endcase
				end
			end
			ST_PAD: begin
				// one zero byte a cycle until the checksum position
				if (fill_q < FW'(IMAGE_BYTES - 2)) begin
					we     = 1'b1;
					sum_d  = sum_next;
					fill_d = fill_q + FW'(1);
				end else begin
					state_d = ST_WR_LO;
				end
			end
			ST_WR_LO: begin
				we      = 1'b1;
				waddr   = AW'(IMAGE_BYTES - 2);
				wdata   = sum_q[7:0];
				state_d = ST_WR_HI;
			end
			ST_WR_HI: begin
				we      = 1'b1;
				waddr   = AW'(IMAGE_BYTES - 1);
				wdata   = sum_q[15:8];
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				// result register frees as soon as its item is taken
				if (!res_valid_q || !res_stall) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= SUM_START;
		end else begin
			fill_q <= fill_d;
			sum_q  <= sum_d;
		end
	end

	// Mirror of the last even-position byte: the odd-position update needs it.
	// The last slot never pairs with a later byte (even address when N is odd).
	always_ff @(posedge clk) begin
		if (we && !waddr[0] && (waddr != AW'(IMAGE_BYTES - 1))) begin
			prev_q <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			cmd_code_q <= cmd_item.command;
			status_q   <= (cmd_item.command == CMD_APPEND) && full;
			rd_ok_q    <= (int'(cmd_item.read_address) < IMAGE_BYTES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.read_data  <= ((cmd_code_q == CMD_READ) && rd_ok_q) ? rdata : 8'd0;
			res_q.status     <= status_q;
			res_q.checksum   <= sum_q;
			res_q.fill_level <= 8'(fill_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// Fill pointer never passes the end of the image.
	`EICB_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FW'(IMAGE_BYTES))
	// Checksum low byte is always followed by the high byte.
	`EICB_ASSERT_NEXT(a_wr_order, state_q == ST_WR_LO, state_q == ST_WR_HI)
	// Restart returns pointer and checksum to their start values.
	`EICB_ASSERT_NEXT(a_restart, accept && cmd_item.command == CMD_RESTART, fill_q == '0 && sum_q == SUM_START)
	// A refused append leaves pointer and checksum alone.
	`EICB_ASSERT_NEXT(a_refused, accept && cmd_item.command == CMD_APPEND && full, $stable(fill_q) && $stable(sum_q))

endmodule

/* test/eeprom_image_checksum_builder_test.sv */
module eeprom_image_checksum_builder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import eicb_pkg::*;

	localparam int N = IMAGE_BYTES_DEF;
	// Total random items, split over the three idling phases.
	localparam int RANDOM_ITEMS = 1700;
	// Longest legal quiet spell is a finish padding from zero plus a long run
	// of receiver stalls; allow many times that.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_PRINTED = 40;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	eicb_cmd_t   cmd_item  = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	eicb_res_t   res_item;

	int          send_idle = 21;
	int          recv_idle = 46;
	int          quiet_cycles = 0;

	// Image shadow, running checksum and the queue of results still owed.
	class image_scoreboard;
		logic [7:0]  image_mem [N];
		bit          written [N];
		int unsigned fill = 0;
		logic [15:0] running = SUM_START;
		eicb_res_t   owed_q [$];
		int          errors = 0;
		int          accepted = 0;
		int          cmd_seen [4];
		int          refused = 0;

		// One byte into the image; odd positions fold the pair into the sum.
		function void put_byte(logic [7:0] b);
			logic [15:0] s;
			if (fill >= N)
				return;
			if (fill[0]) begin
				s = running ^ {b, 8'h00} ^ {8'h00, image_mem[fill - 1]};
				running = {s[14:0], s[15]};
			end
			image_mem[fill] = b;
			written[fill] = 1'b1;
			fill++;
		endfunction

		function void note(eicb_cmd_t c);
			eicb_res_t r;
			r = '0;
			accepted++;
			cmd_seen[c.command]++;
			case (c.command)
			CMD_RESTART: begin
				fill = 0;
				running = SUM_START;
			end
			CMD_APPEND: begin
				if (fill >= N) begin
					r.status = 1'b1;
					refused++;
				end else begin
					put_byte(c.data_byte);
				end
			end
			CMD_FINISH: begin
				while (fill < N - 2)
					put_byte(8'h00);
				// checksum bytes land in the last two slots, pointer untouched
				image_mem[N - 2] = running[7:0];
				image_mem[N - 1] = running[15:8];
				written[N - 2] = 1'b1;
				written[N - 1] = 1'b1;
			end
			default: begin
				if (c.read_address < N)
					r.read_data = image_mem[c.read_address];
			end
			endcase
			r.checksum = running;
			r.fill_level = fill[7:0];
			owed_q.push_back(r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("mismatch %0d at %0t: %s got %0h expected %0h",
					errors, $realtime, what, got, want);
		endtask

		task check(eicb_res_t got);
			eicb_res_t want;
			if (owed_q.size() == 0) begin
				report("result with nothing owed", 64'(got), 64'd0);
				return;
			end
			want = owed_q.pop_front();
			if (got.read_data !== want.read_data)
				report("read_data", 64'(got.read_data), 64'(want.read_data));
			if (got.status !== want.status)
				report("status", 64'(got.status), 64'(want.status));
			if (got.checksum !== want.checksum)
				report("checksum", 64'(got.checksum), 64'(want.checksum));
			if (got.fill_level !== want.fill_level)
				report("fill_level", 64'(got.fill_level), 64'(want.fill_level));
		endtask

		function int owed();
			return owed_q.size();
		endfunction

		// Random position that has been written; -1 while the image is blank.
		function int written_address();
			int start;
			start = $urandom_range(0, N - 1);
			for (int i = 0; i < N; i++)
				if (written[(start + i) % N])
					return (start + i) % N;
			return -1;
		endfunction

		function bit all_written();
			foreach (written[i])
				if (!written[i])
					return 1'b0;
			return 1'b1;
		endfunction
	endclass

	image_scoreboard sb;

	eeprom_image_checksum_builder #(
		.IMAGE_BYTES(N)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: take what arrives, then pick next cycle's stall at random.
	// Outputs and our own inputs only move in the NBA region, so sampling here
	// sees the values from before the edge.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check(res_item);
		res_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	// Watchdog: any handshake on either side resets the quiet count.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Present one item after a random gap, hold it until taken, then note it.
	// Valid stays high on the accept edge; the caller's next drive reuses it.
	task automatic send_item(logic [1:0] op, logic [7:0] data, logic [6:0] addr);
		eicb_cmd_t c;
		c.command = op;
		c.data_byte = data;
		c.read_address = addr;
		while ($urandom_range(0, 99) < send_idle) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_item  <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		sb.note(c);
	endtask

	task automatic send_any(logic [1:0] op);
		send_item(op, 8'($urandom_range(0, 255)), 7'($urandom_range(0, N - 1)));
	endtask

	// Reads only ever target bytes that were written; a blank image gets an
	// append instead.
	task automatic send_read();
		int a;
		a = sb.written_address();
		if (a < 0)
			send_any(CMD_APPEND);
		else
			send_item(CMD_READ, 8'($urandom_range(0, 255)), 7'(a));
	endtask

	// Sender holds off until every owed result is back. Always waits for a
	// clock edge so valid is not lowered and raised in one step.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.owed() != 0);
	endtask

	// Well-formed build: restart, a run of appends, usually a finish, some
	// read-back, now and then appends over the checksum and a second finish.
	task automatic send_image();
		int pick;
		int n;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			n = $urandom_range(0, 16);
		else if (pick < 8)
			n = $urandom_range(17, 125);
		else
			n = $urandom_range(124, 131);
		send_any(CMD_RESTART);
		repeat (n)
			send_any(CMD_APPEND);
		if ($urandom_range(0, 3) != 0)
			send_any(CMD_FINISH);
		repeat ($urandom_range(0, 4))
			send_read();
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 3))
				send_any(CMD_APPEND);
			send_any(CMD_FINISH);
			send_read();
		end
	endtask

	// Noise: commands in any order with random content.
	task automatic send_noise(int n);
		logic [1:0] op;
		repeat (n) begin
			op = 2'($urandom_range(0, 3));
			if (op == CMD_READ)
				send_read();
			else
				send_any(op);
		end
	endtask

	// Directed opener: data extremes, every command, refusal when full,
	// finish with nothing left to pad, restart keeping the image.
	task automatic send_directed();
		send_item(CMD_RESTART, 8'hFF, 7'h7F);
		send_item(CMD_APPEND, 8'h00, 7'h00);
		send_item(CMD_APPEND, 8'hFF, 7'h7F);
		send_item(CMD_APPEND, 8'h5A, 7'h2A);
		send_item(CMD_APPEND, 8'hA5, 7'h55);
		send_item(CMD_READ, 8'h00, 7'd0);
		send_item(CMD_READ, 8'hFF, 7'd3);
		// pads positions 4 to 125, checksum into the last two
		send_item(CMD_FINISH, 8'h3C, 7'h00);
		send_item(CMD_READ, 8'h00, 7'(N - 2));
		send_item(CMD_READ, 8'h00, 7'(N - 1));
		send_item(CMD_READ, 8'h00, 7'd100);
		// appends over the checksum bytes, then one too many
		send_item(CMD_APPEND, 8'h81, 7'h00);
		send_item(CMD_APPEND, 8'h7E, 7'h00);
		send_item(CMD_APPEND, 8'hC3, 7'h00);
		// pointer already past the checksum slot: no padding
		send_item(CMD_FINISH, 8'h00, 7'h7F);
		send_item(CMD_READ, 8'h00, 7'(N - 1));
		// restart keeps the image contents
		send_item(CMD_RESTART, 8'h00, 7'h00);
		send_item(CMD_READ, 8'h00, 7'd1);
		send_item(CMD_APPEND, 8'h3C, 7'h00);
		send_item(CMD_FINISH, 8'h00, 7'h00);
		send_item(CMD_READ, 8'h00, 7'(N - 2));
	endtask

	initial begin : stimulus
		int stop_at;
		sb = new;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		wait_drained();

		// Phase 0: sender 21 % idle, receiver 46 %; phase 1 swapped; phase 2 none.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				send_idle = 21;
				recv_idle = 46;
			end
			1: begin
				send_idle = 46;
				recv_idle = 21;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
			endcase
			stop_at = sb.accepted + RANDOM_ITEMS / 3;
			while (sb.accepted < stop_at) begin
				if ($urandom_range(0, 3) != 0)
					send_image();
				else
					send_noise($urandom_range(1, 12));
				if ($urandom_range(0, 19) == 0)
					wait_drained();
			end
			wait_drained();
		end

		// Let any stray result show up before the verdict.
		repeat (8)
			@(posedge clk);

		$display("covered %0d items: %0d restarts, %0d appends (%0d refused), %0d finishes, %0d reads",
			sb.accepted, sb.cmd_seen[CMD_RESTART], sb.cmd_seen[CMD_APPEND], sb.refused,
			sb.cmd_seen[CMD_FINISH], sb.cmd_seen[CMD_READ]);
		$display("idling 21/46, 46/21 and none; every image byte written: %0d; mismatches: %0d",
			sb.all_written(), sb.errors);
		if (sb.errors == 0 && sb.owed() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/eicb_pkg.sv
rtl/core/eicb_sum_unit.sv
rtl/core/eicb_image_ram.sv
rtl/core/eeprom_image_checksum_builder.sv
test/eeprom_image_checksum_builder_test.sv
